// ----- hdl/mma_pkg.sv -----
package mma_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_LOAD_C  = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ROWS_M  = 2'd0,
    CFG_INNER_N = 2'd1,
    CFG_COLS_K  = 2'd2
  } cfg_index_e;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DIM_W    = 4;
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SUM_W    = PROD_W - FRAC_W + 1;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             lastp;
    logic             add_en;
    logic             last;
  } slot_t;

endpackage

// ----- hdl/mma_ram.sv -----
module mma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/matrix_multiply_accumulate.sv -----
// Load words (kind A, B or C) are accepted one word per cycle while busy is low.
// A compute word runs m*k*max(n,1) issue slots through the memory read port and
// the single multiplier, then drains the pipeline; one C entry per max(n,1) slots.
// Results leave through a registered output word; the receiver cannot stall.
// Reset clears control state and sets the three sizes to 8; stores stay undefined.
module matrix_multiply_accumulate #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  row_index_i,
  input  logic [2:0]  col_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output logic        out_valid_o,
  output logic signed [31:0] out_value_o,
  output logic [2:0]  out_row_o,
  output logic [2:0]  out_col_o,
  output logic        last_o
);

  localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned DW    = mma_pkg::DATA_W;
  localparam int unsigned IW    = mma_pkg::IDX_W;
  localparam int unsigned NW    = mma_pkg::DIM_W;
  localparam int unsigned SW    = mma_pkg::SUM_W;

  logic [NW-1:0] rows_m_q, inner_n_q, cols_k_q;
  logic [NW-1:0] dim_m, dim_n, dim_k;

  logic accept, is_load_a, is_load_b, is_load_c, is_compute;

  logic           run_q;
  logic [IW-1:0]  i_q, j_q, p_q;
  logic           lastp, lastj, lasti;
  mma_pkg::slot_t slot0, slot1_q, slot2_q;
  logic           v1_q, v2_q;

  logic [AW-1:0] a_raddr, b_raddr, c_raddr, ld_addr, wb_addr;
  logic [AW-1:0] c_waddr;
  logic [DW-1:0] a_rdata, b_rdata, c_rdata, c_wdata;
  logic          a_we, b_we, c_we, ld_c_we, wb_we;

  logic signed [mma_pkg::PROD_W-1:0] prod_q;
  logic signed [DW-1:0] c2_q, acc_q, acc_d, base;
  logic signed [SW-1:0] sum;

  logic                  out_valid_q, last_q;
  logic signed [DW-1:0]  out_value_q;
  logic [IW-1:0]         out_row_q, out_col_q;

  function automatic logic [NW-1:0] sat_dim(input logic [NW-1:0] r);
    if (r > NW'(MAX_DIM)) begin
      return NW'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  assign dim_m = sat_dim(rows_m_q);
  assign dim_n = sat_dim(inner_n_q);
  assign dim_k = sat_dim(cols_k_q);

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= mma_pkg::DIM_RESET;
      inner_n_q <= mma_pkg::DIM_RESET;
      cols_k_q  <= mma_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mma_pkg::CFG_ROWS_M:  rows_m_q  <= cfg_data_i;
        mma_pkg::CFG_INNER_N: inner_n_q <= cfg_data_i;
        mma_pkg::CFG_COLS_K:  cols_k_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // word decode
  assign accept     = start && !busy;
  assign is_load_a  = accept && (kind_i == mma_pkg::KIND_LOAD_A);
  assign is_load_b  = accept && (kind_i == mma_pkg::KIND_LOAD_B);
  assign is_load_c  = accept && (kind_i == mma_pkg::KIND_LOAD_C);
  assign is_compute = accept && (kind_i == mma_pkg::KIND_COMPUTE);

  assign ld_addr = cell_addr(row_index_i, col_index_i);
  assign a_we    = is_load_a && ({1'b0, row_index_i} < dim_m) && ({1'b0, col_index_i} < dim_n);
  assign b_we    = is_load_b && ({1'b0, row_index_i} < dim_n) && ({1'b0, col_index_i} < dim_k);
  assign ld_c_we = is_load_c && ({1'b0, row_index_i} < dim_m) && ({1'b0, col_index_i} < dim_k);

  // issue stage
  assign lastp = (dim_n == '0) || ({1'b0, p_q} == dim_n - NW'(1));
  assign lastj = ({1'b0, j_q} == dim_k - NW'(1));
  assign lasti = ({1'b0, i_q} == dim_m - NW'(1));

  always_comb begin
    slot0.row    = i_q;
    slot0.col    = j_q;
    slot0.first  = (p_q == '0);
    slot0.lastp  = lastp;
    slot0.add_en = (dim_n != '0);
    slot0.last   = lastp && lastj && lasti;
  end

  assign a_raddr = cell_addr(i_q, p_q);
  assign b_raddr = cell_addr(p_q, j_q);
  assign c_raddr = cell_addr(i_q, j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      p_q   <= '0;
    end else if (is_compute) begin
      run_q <= (dim_m != '0) && (dim_k != '0);
      i_q   <= '0;
      j_q   <= '0;
      p_q   <= '0;
    end else if (run_q) begin
      if (!lastp) begin
        p_q <= p_q + IW'(1);
      end else begin
        p_q <= '0;
        if (!lastj) begin
          j_q <= j_q + IW'(1);
        end else begin
          j_q <= '0;
          if (!lasti) begin
            i_q <= i_q + IW'(1);
          end else begin
            run_q <= 1'b0;
          end
        end
      end
    end
  end

  // stores
  mma_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mma_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (ld_addr),
    .wdata_i (elem_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign wb_addr = cell_addr(slot2_q.row, slot2_q.col);
  assign wb_we   = v2_q && slot2_q.lastp;
  assign c_we    = ld_c_we || wb_we;
  assign c_waddr = wb_we ? wb_addr : ld_addr;
  assign c_wdata = wb_we ? acc_d : elem_value_i;

  mma_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_store_c (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= run_q;
      v2_q <= v1_q;
    end
  end

  // multiply
  always_ff @(posedge clk_i) begin
    slot1_q <= slot0;
    slot2_q <= slot1_q;
    prod_q  <= $signed(a_rdata) * $signed(b_rdata);
    c2_q    <= c_rdata;
  end

  // accumulate with floor shift and saturation
  assign base = slot2_q.first ? c2_q : acc_q;
  assign sum  = {{(SW-DW){base[DW-1]}}, base} + {prod_q[mma_pkg::PROD_W-1],
                prod_q[mma_pkg::PROD_W-1:mma_pkg::FRAC_W]};

  always_comb begin
    if (!slot2_q.add_en) begin
      acc_d = base;
    end else if (!sum[SW-1] && (sum[SW-2:DW-1] != '0)) begin
      acc_d = {1'b0, {(DW-1){1'b1}}};
    end else if (sum[SW-1] && (sum[SW-2:DW-1] != '1)) begin
      acc_d = {1'b1, {(DW-1){1'b0}}};
    end else begin
      acc_d = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= wb_we;
      last_q      <= wb_we && slot2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_we) begin
      out_value_q <= acc_d;
      out_row_q   <= slot2_q.row;
      out_col_q   <= slot2_q.col;
    end
  end

  assign busy        = run_q || v1_q || v2_q;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

  a_last_has_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o)
    else $error("last without result");

  a_out_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("result outside a compute run");

  a_c_port_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_c_we && wb_we))
    else $error("C load collides with write-back");

  a_run_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_compute && (dim_m != '0) && (dim_k != '0)) |=> busy)
    else $error("compute word did not start a run");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && slot2_q.last) |-> (!run_q && !v1_q))
    else $error("run continues past its last entry");

endmodule
